// ===== hdl/mhs_pkg.sv =====
// Shared constants and types for the ascending sorter built from a row of cells.
`timescale 1ns / 1ps

package mhs_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_e;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cell_ctrl_t;

endpackage

// ===== hdl/mhs_cell.sv =====
// One sorting cell: holds a single value, takes part in parallel insertion and shift-out.
`timescale 1ns / 1ps

module mhs_cell (
  input  logic                            clk_i,
  input  mhs_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            occ_i,
  input  logic signed [mhs_pkg::DATA_W-1:0] value_i,
  input  logic                            lower_ins_i,
  input  logic signed [mhs_pkg::DATA_W-1:0] lower_val_i,
  input  logic signed [mhs_pkg::DATA_W-1:0] upper_val_i,
  output logic                            ins_o,
  output logic signed [mhs_pkg::DATA_W-1:0] val_o
);

  logic signed [mhs_pkg::DATA_W-1:0] val_q;
  logic signed [mhs_pkg::DATA_W-1:0] val_d;

  // new value belongs at or below this slot
  assign ins_o = !occ_i || (value_i < val_q);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.pop_en) begin
      val_d = upper_val_i;
    end else if (ctrl_i.ins_en && ins_o) begin
      val_d = lower_ins_i ? lower_val_i : value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== hdl/max_heap_sorter.sv =====
// Top level: collects signed values in a sorted row of cells and streams them out ascending.
//
//  channel   | dir | tdata                  | tlast      | tuser
//  s_axis    | in  | [31:0] value           | last       | -
//  m_axis    | out | [31:0] sorted_value    | final_res  | dropped
//
//  An input beat is inserted with all cells comparing against it in parallel.
//  A beat with tlast starts emission: one result per cycle from the lowest cell while the
//  output stage is not stalled, s_axis_tready low until the last one is loaded.
//  A registered output stage holds a result while m_axis_tready is low.
//  Reset clears the count, drop flag, output valid and state; cell contents need no reset.
`timescale 1ns / 1ps

module max_heap_sorter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,   // final_res
  output logic        m_axis_tuser    // [0] dropped
);

  localparam int unsigned N = mhs_pkg::CAPACITY;

  mhs_pkg::state_e st_q, st_d;
  logic [mhs_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;
  logic m_valid_q, m_valid_d;
  logic [mhs_pkg::DATA_W-1:0] m_data_q, m_data_d;
  logic m_last_q, m_last_d;
  logic m_drop_q, m_drop_d;

  logic accept, full, pop;
  mhs_pkg::cell_ctrl_t ctrl;

  logic signed [mhs_pkg::DATA_W-1:0] cell_val [N];
  logic [N-1:0] cell_ins;
  logic [N-1:0] occ;

  assign full   = (cnt_q == mhs_pkg::CNT_W'(N));
  assign accept = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [mhs_pkg::DATA_W-1:0] lower_val, upper_val;
    logic lower_ins;

    assign occ[i] = (cnt_q > mhs_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign lower_val = '0;
      assign lower_ins = 1'b0;
    end else begin : g_mid
      assign lower_val = cell_val[i-1];
      assign lower_ins = cell_ins[i-1];
    end

    if (i == N - 1) begin : g_top
      assign upper_val = '0;
    end else begin : g_below
      assign upper_val = cell_val[i+1];
    end

    mhs_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .value_i     (s_axis_tdata),
      .lower_ins_i (lower_ins),
      .lower_val_i (lower_val),
      .upper_val_i (upper_val),
      .ins_o       (cell_ins[i]),
      .val_o       (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= mhs_pkg::ST_FILL;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_drop_q <= m_drop_d;
  end

  always_comb begin
    st_d          = st_q;
    cnt_d         = cnt_q;
    ovf_d         = ovf_q;
    m_valid_d     = m_valid_q;
    m_data_d      = m_data_q;
    m_last_d      = m_last_q;
    m_drop_d      = m_drop_q;
    s_axis_tready = 1'b0;
    pop           = 1'b0;
    ctrl          = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (st_q)
      mhs_pkg::ST_FILL: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.ins_en = 1'b1;
            cnt_d       = cnt_q + 1'b1;
          end
          if (s_axis_tlast) begin
            st_d = mhs_pkg::ST_EMIT;
          end
        end
      end
      mhs_pkg::ST_EMIT: begin
        pop = !m_valid_q || m_axis_tready;
        if (pop) begin
          ctrl.pop_en = 1'b1;
          m_valid_d   = 1'b1;
          m_data_d    = cell_val[0];
          m_last_d    = (cnt_q == mhs_pkg::CNT_W'(1));
          m_drop_d    = ovf_q;
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == mhs_pkg::CNT_W'(1)) begin
            ovf_d = 1'b0;
            st_d  = mhs_pkg::ST_FILL;
          end
        end
      end
      default: begin
        st_d = mhs_pkg::ST_FILL;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_drop_q;

endmodule

// ===== hdl/mhs_checker.sv =====
// Port-level checks for max_heap_sorter, bound to the top level.
`timescale 1ns / 1ps

module mhs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a closing input beat always shuts the input side for emission
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after closing beat");

  // input reopens only as the final result of the run is presented
  a_reopen_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> (m_axis_tvalid && m_axis_tlast))
    else $error("input reopened without final result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

endmodule

bind max_heap_sorter mhs_checker u_mhs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
